>>> hdl/ptn_pkg.sv
// Package: shared types, codes and constants of the tile neighbour core.
`timescale 1ns / 1ps

package ptn_pkg;

  // Field widths
  localparam int unsigned IdW    = 32;
  localparam int unsigned KindW  = 3;
  localparam int unsigned LevelW = 4;
  localparam int unsigned XW     = 16;
  localparam int unsigned YW     = 15;

  // Deepest level an id may carry
  localparam int unsigned MaxLevel = 15;

  // Level marker for level zero sits at bit 16
  localparam logic [IdW-1:0] MarkerBase = 32'h0001_0000;

  // Direction codes
  typedef enum logic [KindW-1:0] {
    KIND_DECODE = 3'd0,
    KIND_WEST   = 3'd1,
    KIND_EAST   = 3'd2,
    KIND_SOUTH  = 3'd3,
    KIND_NORTH  = 3'd4
  } kind_t;

  // Decoded view of one tile id, passed from decoder to stepper
  typedef struct packed {
    logic              ok;
    logic [LevelW-1:0] lvl;
    logic [IdW-1:0]    marker;
    logic [XW-1:0]     x;
    logic [YW-1:0]     y;
  } ptn_dec_t;

endpackage

>>> hdl/ptn_decode.sv
// Tile id decoder: level search, validity check and Morton deinterleave.
`timescale 1ns / 1ps

module ptn_decode (
  input  logic [ptn_pkg::IdW-1:0] tile_id,
  output ptn_pkg::ptn_dec_t       dec
);
  import ptn_pkg::*;

  logic [15:0]       top;
  logic [LevelW-1:0] lvl;
  logic [IdW-1:0]    marker;
  logic [IdW-1:0]    morton;
  logic [IdW-1:0]    excess;
  logic              ok;
  logic [XW-1:0]     x_raw;
  logic [YW-1:0]     y_raw;

  assign top = tile_id[31:16];

  // Level: index of the highest set bit of the top half, 0 when top is 0 or 1
  always_comb begin
    lvl = '0;
    for (int i = 1; i < 16; i++) begin
      if (top[i]) begin
        lvl = LevelW'(i);
      end
    end
  end

  // Strip the marker and check that nothing sits above bit 2*level
  assign marker = MarkerBase << lvl;
  assign morton = tile_id & ~marker;
  assign excess = morton >> {lvl, 1'b1};
  assign ok     = (|top) && (lvl <= LevelW'(MaxLevel)) && (excess == '0);

  // Deinterleave: x on even bits, y on odd bits
  always_comb begin
    for (int i = 0; i < XW; i++) begin
      x_raw[i] = morton[2*i];
    end
    for (int i = 0; i < YW; i++) begin
      y_raw[i] = morton[2*i+1];
    end
  end

  assign dec.ok     = ok;
  assign dec.lvl    = lvl;
  assign dec.marker = marker;
  assign dec.x      = ok ? x_raw : '0;
  assign dec.y      = ok ? y_raw : '0;

endmodule

>>> hdl/ptn_step.sv
// Neighbour stepper: wrapped grid step and Morton reinterleave.
`timescale 1ns / 1ps

module ptn_step (
  input  ptn_pkg::ptn_dec_t         dec,
  input  logic [ptn_pkg::KindW-1:0] kind,
  output logic [ptn_pkg::IdW-1:0]   neighbour_id
);
  import ptn_pkg::*;

  logic [XW-1:0]  xmask;
  logic [YW-1:0]  ymask;
  logic [XW-1:0]  nx;
  logic [YW-1:0]  ny;
  logic [IdW-1:0] joined;

  // x keeps level+1 bits, y keeps level bits
  assign xmask = ~({XW{1'b1}} << ({1'b0, dec.lvl} + 5'd1));
  assign ymask = ~({YW{1'b1}} << dec.lvl);

  // One step in the requested direction; unused codes decode only
  always_comb begin
    nx = dec.x;
    ny = dec.y;
    unique case (kind)
      KIND_WEST:  nx = (dec.x - XW'(1)) & xmask;
      KIND_EAST:  nx = (dec.x + XW'(1)) & xmask;
      KIND_SOUTH: ny = (dec.y - YW'(1)) & ymask;
      KIND_NORTH: ny = (dec.y + YW'(1)) & ymask;
      default: ;
    endcase
  end

  // Reinterleave; bit 31 is never a Morton bit
  always_comb begin
    joined = '0;
    for (int i = 0; i < XW; i++) begin
      joined[2*i] = nx[i];
    end
    for (int i = 0; i < YW; i++) begin
      joined[2*i+1] = ny[i];
    end
  end

  assign neighbour_id = dec.ok ? (joined | dec.marker) : '0;

endmodule

>>> hdl/packed_tile_neighbour_core.sv
// Top level of the packed tile neighbour core.
//
// Usage:
//   Input: drive in_tile_id and in_kind with start high; the transaction is
//   taken at the rising edge where start is high and busy is low. busy is
//   always low, so a new tile id may be issued on every cycle.
//   Output: each transaction yields one result, shown for exactly one cycle
//   with out_valid high: neighbour id, decoded level, x/y grid index of the
//   input tile and the id_ok flag. Invalid ids give a zero neighbour and
//   zero grid indices while the level is still reported.
//   Pipeline: a taken transaction is held in the input register, and its
//   result is shown from the result register. Throughput is one transaction
//   per cycle, set by the input register and result register with one pass
//   of decode and step logic between them.
//   Reset: synchronous, active low on rst_n; it clears the pipeline valid
//   flags, so no result is shown until a new transaction is taken.
//   The receiver has no way to stall: a result not taken in its cycle is gone.
`timescale 1ns / 1ps

module packed_tile_neighbour_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ptn_pkg::IdW-1:0]     in_tile_id,
  input  logic [ptn_pkg::KindW-1:0]   in_kind,
  output logic                        out_valid,
  output logic [ptn_pkg::IdW-1:0]     out_neighbour_id,
  output logic [ptn_pkg::LevelW-1:0]  out_tile_level,
  output logic [ptn_pkg::XW-1:0]      out_grid_x,
  output logic [ptn_pkg::YW-1:0]      out_grid_y,
  output logic                        out_id_ok
);
  import ptn_pkg::*;

  logic              in_vld_r;
  logic [IdW-1:0]    id_r;
  logic [KindW-1:0]  kind_r;
  ptn_dec_t          dec;
  logic [IdW-1:0]    nbr;
  logic              out_vld_r;
  logic [IdW-1:0]    nbr_r;
  logic [LevelW-1:0] lvl_r;
  logic [XW-1:0]     x_r;
  logic [YW-1:0]     y_r;
  logic              ok_r;

  // Never stalls the sender
  assign busy = 1'b0;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      id_r   <= in_tile_id;
      kind_r <= in_kind;
    end
  end

  // Decode and step
  ptn_decode u_decode (
    .tile_id (id_r),
    .dec     (dec)
  );

  ptn_step u_step (
    .dec          (dec),
    .kind         (kind_r),
    .neighbour_id (nbr)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      nbr_r <= nbr;
      lvl_r <= dec.lvl;
      x_r   <= dec.x;
      y_r   <= dec.y;
      ok_r  <= dec.ok;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_neighbour_id = nbr_r;
  assign out_tile_level   = lvl_r;
  assign out_grid_x       = x_r;
  assign out_grid_y       = y_r;
  assign out_id_ok        = ok_r;

`ifndef SYNTHESIS
  // Every transaction in the input stage reaches the result in the next cycle
  a_stage_follow: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r |=> out_valid)
    else $error("result strobe missing after input stage");

  // Invalid ids produce an all-zero neighbour and grid index
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_id_ok) |->
      (out_neighbour_id == '0 && out_grid_x == '0 && out_grid_y == '0))
    else $error("invalid id gave nonzero result");

  // A valid neighbour carries the marker of the same level as its top bit
  a_marker_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_id_ok) |->
      ((out_neighbour_id >> ({1'b0, out_tile_level} + 5'd16)) == 32'd1))
    else $error("neighbour lost its level marker");

  // Grid indices stay inside the level's width
  a_grid_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_id_ok) |->
      ((out_grid_x >> ({1'b0, out_tile_level} + 5'd1)) == '0 &&
       (out_grid_y >> out_tile_level) == '0))
    else $error("grid index wider than level allows");
`endif

endmodule

>>> test/tb.sv
// Testbench for the packed tile neighbour core: directed and random lookups
// checked against a predictor.
`timescale 1ns / 1ps

module tb;
  import ptn_pkg::*;

  // One result transaction as seen on the out_ ports
  typedef struct packed {
    logic [IdW-1:0]    neighbour_id;
    logic [LevelW-1:0] tile_level;
    logic [XW-1:0]     grid_x;
    logic [YW-1:0]     grid_y;
    logic              id_ok;
  } tile_result_t;

  // Expected neighbour lookups, oldest first, and the checks against them
  class neighbour_scoreboard;
    tile_result_t expected_q[$];
    int unsigned  errors;
    int unsigned  checked;
    int unsigned  valid_seen;

    // Neighbour lookup on one tile id: decode level, split Morton, step, rejoin
    static function tile_result_t predict_neighbour(logic [IdW-1:0] id,
                                                    logic [KindW-1:0] kind);
      tile_result_t   r;
      logic [3:0]     lvl;
      logic [31:0]    marker;
      logic [31:0]    morton;
      logic [31:0]    joined;
      logic [15:0]    x, nx, xmask;
      logic [14:0]    y, ny, ymask;
      r = '0;
      lvl = '0;
      // highest set bit of the top half wins
      for (int i = 1; i < 16; i++) begin
        if (id[16+i]) lvl = i[3:0];
      end
      r.tile_level = lvl;
      marker = 32'h1 << (16 + lvl);
      morton = id - marker;
      if (id >= MarkerBase && (64'(morton) >> (2 * lvl + 1)) == 64'd0) begin
        x = '0;
        y = '0;
        for (int i = 0; i < lvl; i++) begin
          x[i] = morton[2*i];
          y[i] = morton[2*i+1];
        end
        x[lvl] = morton[2*lvl];
        xmask = 16'((32'h1 << (lvl + 1)) - 1);
        ymask = 15'((32'h1 << lvl) - 1);
        nx = x;
        ny = y;
        case (kind)
          KIND_WEST:  nx = (x - 16'd1) & xmask;
          KIND_EAST:  nx = (x + 16'd1) & xmask;
          KIND_SOUTH: ny = (y - 15'd1) & ymask;
          KIND_NORTH: ny = (y + 15'd1) & ymask;
          default: ;
        endcase
        joined = '0;
        for (int i = 0; i < lvl; i++) begin
          joined[2*i]   = nx[i];
          joined[2*i+1] = ny[i];
        end
        joined[2*lvl] = nx[lvl];
        r.neighbour_id = joined + marker;
        r.grid_x = x;
        r.grid_y = y;
        r.id_ok = 1'b1;
      end
      return r;
    endfunction

    function void note_input(logic [IdW-1:0] id, logic [KindW-1:0] kind);
      expected_q.insert(expected_q.size(), predict_neighbour(id, kind));
    endfunction

    function void check_result(tile_result_t got);
      tile_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result: neighbour_id %h", got.neighbour_id);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (exp_r.id_ok) valid_seen++;
      if (got.neighbour_id !== exp_r.neighbour_id) begin
        $error("neighbour_id: expected %h, got %h", exp_r.neighbour_id, got.neighbour_id);
        errors++;
      end
      if (got.tile_level !== exp_r.tile_level) begin
        $error("tile_level: expected %0d, got %0d", exp_r.tile_level, got.tile_level);
        errors++;
      end
      if (got.grid_x !== exp_r.grid_x) begin
        $error("grid_x: expected %h, got %h", exp_r.grid_x, got.grid_x);
        errors++;
      end
      if (got.grid_y !== exp_r.grid_y) begin
        $error("grid_y: expected %h, got %h", exp_r.grid_y, got.grid_y);
        errors++;
      end
      if (got.id_ok !== exp_r.id_ok) begin
        $error("id_ok: expected %0d, got %0d", exp_r.id_ok, got.id_ok);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [IdW-1:0]    in_tile_id;
  logic [KindW-1:0]  in_kind;
  logic              out_valid;
  logic [IdW-1:0]    out_neighbour_id;
  logic [LevelW-1:0] out_tile_level;
  logic [XW-1:0]     out_grid_x;
  logic [YW-1:0]     out_grid_y;
  logic              out_id_ok;

  neighbour_scoreboard sb = new();

  packed_tile_neighbour_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_tile_id       (in_tile_id),
    .in_kind          (in_kind),
    .out_valid        (out_valid),
    .out_neighbour_id (out_neighbour_id),
    .out_tile_level   (out_tile_level),
    .out_grid_x       (out_grid_x),
    .out_grid_y       (out_grid_y),
    .out_id_ok        (out_id_ok)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Watch both channels at each edge
  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_input(in_tile_id, in_kind);
    if (rst_n && out_valid) begin
      sb.check_result('{out_neighbour_id, out_tile_level, out_grid_x, out_grid_y,
                        out_id_ok});
    end
  end

  // Present one lookup after an idle gap; returns at the edge that takes it
  task automatic issue_lookup(logic [IdW-1:0] id, logic [KindW-1:0] kind,
                              int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_tile_id <= id;
    in_kind    <= kind;
    do @(posedge clk); while (busy);
  endtask

  // Hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // Stimulus
  initial begin
    logic [34:0]      directed_q[$];
    logic [IdW-1:0]   id;
    logic [KindW-1:0] kind;
    logic [31:0]      morton;
    logic [31:0]      mmask;
    int unsigned      lvl;
    int unsigned      gap;
    int unsigned      sel;

    rst_n      = 1'b0;
    start      = 1'b0;
    in_tile_id = '0;
    in_kind    = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ids below the minimum, level zero, level one, level 15 corners,
    // wrap at both masks, the spare kind codes and oversized Morton numbers
    directed_q = '{
      {KIND_DECODE, 32'h0000_0000}, {KIND_EAST,   32'h0000_FFFF},
      {KIND_WEST,   32'h0001_0000}, {KIND_EAST,   32'h0001_0000},
      {KIND_SOUTH,  32'h0001_0000}, {KIND_NORTH,  32'h0001_0000},
      {KIND_EAST,   32'h0001_0001}, {KIND_DECODE, 32'h0001_0002},
      {KIND_SOUTH,  32'h0002_0000}, {KIND_NORTH,  32'h0002_0007},
      {KIND_WEST,   32'h0002_0000}, {KIND_DECODE, 32'h0002_0008},
      {KIND_WEST,   32'h8000_0000}, {KIND_SOUTH,  32'h8000_0000},
      {KIND_EAST,   32'hFFFF_FFFF}, {KIND_NORTH,  32'hFFFF_FFFF},
      {3'd5,        32'hFFFF_FFFF}, {3'd6,        32'h8555_5555},
      {3'd7,        32'h0001_0000}, {KIND_DECODE, 32'h7FFF_FFFF},
      {KIND_EAST,   32'h5FFF_FFFF}, {KIND_NORTH,  32'h4AAA_AAAA}
    };
    foreach (directed_q[i]) begin
      issue_lookup(directed_q[i][31:0], directed_q[i][34:32], $urandom_range(0, 2));
    end

    // Random: mostly well-formed ids, some with Morton out of range, some noise
    for (int n = 0; n < 1500; n++) begin
      sel = $urandom_range(0, 99);
      lvl = $urandom_range(0, 15);
      mmask = 32'((64'h1 << (2 * lvl + 1)) - 1);
      if (sel < 55) begin
        morton = $urandom & mmask;
        id = (32'h1 << (16 + lvl)) | morton;
      end else if (sel < 70) begin
        // x or y at an edge of its range
        case ($urandom_range(0, 3))
          0: morton = '0;
          1: morton = mmask;
          2: morton = 32'h5555_5555 & mmask;
          default: morton = 32'hAAAA_AAAA & mmask;
        endcase
        id = (32'h1 << (16 + lvl)) | morton;
      end else if (sel < 85) begin
        // Morton number above the limit for its level
        lvl = $urandom_range(0, 14);
        morton = $urandom & ((32'h1 << (16 + lvl)) - 1);
        morton |= 32'h1 << $urandom_range(2 * lvl + 1, 15 + lvl);
        id = (32'h1 << (16 + lvl)) | morton;
      end else if (sel < 95) begin
        id = $urandom;
      end else begin
        id = $urandom_range(0, 32'hFFFF);
      end
      kind = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
      gap = ((n / 100) % 3 == 1) ? 0 : $urandom_range(0, 9);

      // once, let the pipeline drain completely before going on; one edge
      // first so the last accepted transaction is already queued
      if (n == 700) begin
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
      end
      issue_lookup(id, kind, gap);
    end
    start <= 1'b0;

    // Drain, then a few quiet cycles to catch stray results
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("tb: %0d lookups checked, %0d on valid ids, %0d on invalid ids",
             sb.checked, sb.valid_seen, sb.checked - sb.valid_seen);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
